// ===== rtl/pcpd_pkg.sv =====
package pcpd_pkg;

    localparam int MAX_DIM_DEF = 1024;

    localparam int COL_W       = 10;
    localparam int BYTE_W      = 8;
    localparam int ADDR_W      = 20;
    localparam int CFG_DIM_W   = 11;
    localparam int ORIGIN_W    = 12;
    localparam int COORD_W     = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 2'd3;

    localparam logic [CFG_DIM_W-1:0] DEST_WIDTH_RST  = 11'd320;
    localparam logic [CFG_DIM_W-1:0] DEST_HEIGHT_RST = 11'd200;

    localparam logic [BYTE_W-1:0] END_MARK = 8'hFF;

    typedef struct packed {
        logic               is_end;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [BYTE_W-1:0]  value;
    } draw_op_t;

endpackage

// ===== rtl/pcpd_in_if.sv =====
interface pcpd_in_if
    import pcpd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [COL_W-1:0]  column_index;
    logic              column_start;
    logic [BYTE_W-1:0] post_byte;

    modport source (output valid, output column_index, output column_start,
                    output post_byte, input ready);
    modport sink   (input valid, input column_index, input column_start,
                    input post_byte, output ready);
endinterface

// ===== rtl/pcpd_out_if.sv =====
interface pcpd_out_if
    import pcpd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              is_column_end;
    logic [ADDR_W-1:0] pixel_address;
    logic [BYTE_W-1:0] pixel_value;

    modport source (output valid, output is_column_end, output pixel_address,
                    output pixel_value, input ready);
    modport sink   (input valid, input is_column_end, input pixel_address,
                    input pixel_value, output ready);
endinterface

// ===== rtl/patch_column_post_drawer.sv =====
// An accepted byte that yields a result goes into the queue, then into the output register.
// Throughput: one byte per cycle while the queue has room; the back stage's single row-times-width
// multiply drains one item per cycle while output is not stalled; a four-entry queue absorbs stalls.
// Reset: width 320, height 200, origins 0, parser expects a post top offset, queue and
// output register empty; no clearing pass.
module patch_column_post_drawer
    import pcpd_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    pcpd_in_if.sink               byte_ch,
    pcpd_out_if.source            write_ch,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int CW = (DW > CFG_DIM_W) ? DW : CFG_DIM_W;

    logic [CFG_DIM_W-1:0]        dest_width_reg, dest_height_reg;
    logic signed [ORIGIN_W-1:0]  origin_x_reg, origin_y_reg;
    logic [CW-1:0]               width_ext, height_ext;
    logic [DW-1:0]               dim_w, dim_h;
    logic                        q_full, push, pop, head_valid;
    draw_op_t                    push_op, head_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_width_reg  <= DEST_WIDTH_RST;
            dest_height_reg <= DEST_HEIGHT_RST;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_DEST_WIDTH:  dest_width_reg  <= cfg_data[CFG_DIM_W-1:0];
                REG_DEST_HEIGHT: dest_height_reg <= cfg_data[CFG_DIM_W-1:0];
                REG_ORIGIN_X:    origin_x_reg    <= $signed(cfg_data[ORIGIN_W-1:0]);
                REG_ORIGIN_Y:    origin_y_reg    <= $signed(cfg_data[ORIGIN_W-1:0]);
            endcase
        end
    end

    // clamp dimensions to the largest supported size
    assign width_ext  = CW'(dest_width_reg);
    assign height_ext = CW'(dest_height_reg);
    assign dim_w = (width_ext > CW'(MAX_DIM))  ? DW'(MAX_DIM) : DW'(width_ext);
    assign dim_h = (height_ext > CW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(height_ext);

    pcpd_front #(.MAX_DIM(MAX_DIM)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_ch  (byte_ch),
        .dim_w    (dim_w),
        .dim_h    (dim_h),
        .origin_x (origin_x_reg),
        .origin_y (origin_y_reg),
        .q_full   (q_full),
        .push     (push),
        .push_op  (push_op)
    );

    pcpd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    pcpd_back #(.MAX_DIM(MAX_DIM)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .dim_w      (dim_w),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop),
        .write_ch   (write_ch)
    );

endmodule

// ===== rtl/pcpd_front.sv =====
module pcpd_front
    import pcpd_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF,
    localparam int DW = $clog2(MAX_DIM + 1)
)(
    input  logic                       clk,
    input  logic                       rst_n,
    pcpd_in_if.sink                    byte_ch,
    input  logic [DW-1:0]              dim_w,
    input  logic [DW-1:0]              dim_h,
    input  logic signed [ORIGIN_W-1:0] origin_x,
    input  logic signed [ORIGIN_W-1:0] origin_y,
    input  logic                       q_full,
    output logic                       push,
    output draw_op_t                   push_op
);

    localparam logic [2:0] PH_TOP  = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_PAD1 = 3'd2;
    localparam logic [2:0] PH_PIX  = 3'd3;
    localparam logic [2:0] PH_PAD2 = 3'd4;

    localparam int SW   = ORIGIN_W + 1;
    localparam int CMPW = ((DW > SW) ? DW : SW) + 1;

    logic [2:0]        phase_reg, phase_next, phase_eff;
    logic [BYTE_W-1:0] top_reg, top_next;
    logic [BYTE_W-1:0] left_reg, left_next, left_dec;
    logic [BYTE_W-1:0] row_reg, row_next;
    logic              accept;
    logic [SW-1:0]     dx, dy;
    logic [CMPW-1:0]   dx_ext, dy_ext, w_ext, h_ext;
    logic              in_view;

    assign byte_ch.ready = !q_full;
    assign accept        = byte_ch.valid && byte_ch.ready;

    assign dx = {origin_x[ORIGIN_W-1], origin_x}
              + {{(SW-COL_W){1'b0}}, byte_ch.column_index};
    assign dy = {origin_y[ORIGIN_W-1], origin_y}
              + {{(SW-BYTE_W){1'b0}}, top_reg}
              + {{(SW-BYTE_W){1'b0}}, row_reg};

    assign dx_ext = {{(CMPW-SW){dx[SW-1]}}, dx};
    assign dy_ext = {{(CMPW-SW){dy[SW-1]}}, dy};
    assign w_ext  = {{(CMPW-DW){1'b0}}, dim_w};
    assign h_ext  = {{(CMPW-DW){1'b0}}, dim_h};

    assign in_view = !dx[SW-1] && ($signed(dx_ext) < $signed(w_ext))
                  && !dy[SW-1] && ($signed(dy_ext) < $signed(h_ext));

    assign phase_eff = byte_ch.column_start ? PH_TOP : phase_reg;
    assign left_dec  = left_reg - 8'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        top_next      = top_reg;
        left_next     = left_reg;
        row_next      = row_reg;
        push          = 1'b0;
        push_op.is_end = 1'b0;
        push_op.x     = dx[COORD_W-1:0];
        push_op.y     = dy[COORD_W-1:0];
        push_op.value = byte_ch.post_byte;
        if (accept)
        begin
            phase_next = phase_eff;
            unique case (phase_eff)
                PH_TOP:
                begin
                    if (byte_ch.post_byte == END_MARK)
                    begin
                        push           = 1'b1;
                        push_op.is_end = 1'b1;
                    end
                    else
                    begin
                        top_next   = byte_ch.post_byte;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    left_next  = byte_ch.post_byte;
                    row_next   = '0;
                    phase_next = PH_PAD1;
                end
                PH_PAD1:
                begin
                    phase_next = (left_reg == '0) ? PH_PAD2 : PH_PIX;
                end
                PH_PIX:
                begin
                    push      = in_view;
                    row_next  = row_reg + 8'd1;
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        phase_next = PH_PAD2;
                    end
                end
                default:
                begin
                    phase_next = PH_TOP;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TOP;
            top_reg   <= '0;
            left_reg  <= '0;
            row_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            top_reg   <= top_next;
            left_reg  <= left_next;
            row_reg   <= row_next;
        end
    end

endmodule

// ===== rtl/pcpd_queue.sv =====
module pcpd_queue
    import pcpd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  draw_op_t push_op,
    input  logic     pop,
    output logic     full,
    output logic     head_valid,
    output draw_op_t head_op
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    draw_op_t        mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg, count_next;

    assign full       = (count_reg == CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("queue count lost a push");

endmodule

// ===== rtl/pcpd_back.sv =====
module pcpd_back
    import pcpd_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF,
    localparam int DW = $clog2(MAX_DIM + 1)
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [DW-1:0] dim_w,
    input  logic          head_valid,
    input  draw_op_t      head_op,
    output logic          pop,
    pcpd_out_if.source    write_ch
);

    localparam int PRW = DW + COORD_W;
    localparam int AW  = ((PRW + 1) > ADDR_W) ? (PRW + 1) : ADDR_W;

    logic              valid_reg;
    logic              end_reg;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [BYTE_W-1:0] value_reg;
    logic [PRW-1:0]    product;
    logic [AW-1:0]     sum;

    assign pop = head_valid && (!valid_reg || write_ch.ready);

    assign product = PRW'(head_op.y) * PRW'(dim_w);
    assign sum     = AW'(product) + AW'(head_op.x);
    assign addr_next = head_op.is_end ? '0 : sum[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (write_ch.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            end_reg   <= head_op.is_end;
            addr_reg  <= addr_next;
            value_reg <= head_op.is_end ? '0 : head_op.value;
        end
    end

    assign write_ch.valid         = valid_reg;
    assign write_ch.is_column_end = end_reg;
    assign write_ch.pixel_address = addr_reg;
    assign write_ch.pixel_value   = value_reg;

endmodule
